>>> hw/rtl/vna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and codes of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int IDX_W   = 12;
    localparam int FIELD_W = 16;
    localparam int SUM_W   = 40;
    localparam int UNIT_W  = 15;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic        [1:0]         operation;
        logic        [IDX_W-1:0]   index_a;
        logic        [IDX_W-1:0]   index_b;
        logic        [IDX_W-1:0]   index_c;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic        [1:0]         kind;
        logic signed [FIELD_W-1:0] normal_x;
        logic signed [FIELD_W-1:0] normal_y;
        logic signed [FIELD_W-1:0] normal_z;
        logic                      zero_length;
        logic                      saturated;
    } out_item_t;

    typedef struct packed {
        logic        [FIELD_W-1:0] nx;
        logic        [FIELD_W-1:0] ny;
        logic        [FIELD_W-1:0] nz;
        logic                      zero;
    } norm_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/vna_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port; a read of the address being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/vna_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vna_front
// Input side: folds vertex indices into the memory depth and queues
// transactions for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module vna_front
    import vna_pkg::*;
#(
    parameter int VERTEX_DEPTH = 4096
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t item,
    output logic          full,
    output logic          q_valid,
    output in_item_t      q_item,
    input  wire logic     q_pop
);

    localparam int              WRAP    = (VERTEX_DEPTH < (1 << IDX_W)) ? 1 : 0;
    localparam int              RECIP   = ((1 << 24) + VERTEX_DEPTH - 1) / VERTEX_DEPTH;
    localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(VERTEX_DEPTH);
    localparam int              QDEPTH  = 2;

    // index modulo depth by reciprocal multiply; exact when depth is at least 8
    function automatic logic [IDX_W-1:0] fold(input logic [IDX_W-1:0] idx);
        logic [32:0]      prod;
        logic [IDX_W-1:0] quo;
        prod = 33'(idx) * 33'(RECIP);
        quo  = IDX_W'(prod[32:24]);
        if (WRAP != 0)
        begin
            fold = idx - IDX_W'(quo * DEPTH_I);
        end
        else
        begin
            fold = idx;
        end
    endfunction

    in_item_t folded;
    in_item_t q_reg [QDEPTH];
    logic     wr_ptr_reg, wr_ptr_next;
    logic     rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic     do_push;

    // classify: reduce the three indices
    always_comb
    begin
        folded         = item;
        folded.index_a = fold(item.index_a);
        folded.index_b = fold(item.index_b);
        folded.index_c = fold(item.index_c);
    end

    assign full    = (count_reg == 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];
    assign do_push = push && !full;

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold queued payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= folded;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/vna_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vna_norm
// Scales a 40-bit normal sum to unit length in Q1.14: shift search, sum of
// squares, then a bit-serial rounded quotient search per component.
// ----------------------------------------------------------------------------
module vna_norm
    import vna_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] sum_x,
    input  wire logic signed [SUM_W-1:0] sum_y,
    input  wire logic signed [SUM_W-1:0] sum_z,
    output logic                         done,
    output norm_res_t                    res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_TSQ   = 3'd3;
    localparam logic [2:0] N_MUL   = 3'd4;
    localparam logic [2:0] N_CMP   = 3'd5;
    localparam logic [2:0] N_OUT   = 3'd6;

    localparam logic [UNIT_W-1:0] ONE = UNIT_W'(16384);

    logic [2:0]        state_reg;
    logic [SUM_W-1:0]  a_reg   [3];
    logic              neg_reg [3];
    logic [31:0]       sq_reg  [3];
    logic [UNIT_W-1:0] m_reg   [3];
    logic [33:0]       len_reg;
    logic [31:0]       tt_reg;
    logic [48:0]       plo_reg, phi_reg;
    logic [UNIT_W-1:0] r_reg, bit_reg;
    logic [1:0]        k_reg;
    logic              zero_reg;

    logic [SUM_W-1:0]  big;
    logic [SUM_W-1:0]  a_sel;
    logic [31:0]       sq_sel;
    logic [UNIT_W-1:0] q;
    logic [15:0]       t;
    logic [65:0]       lhs, rhs;
    logic              take;

    // largest magnitude and per-component selects
    always_comb
    begin
        big = a_reg[0];
        if (a_reg[1] > big)
        begin
            big = a_reg[1];
        end
        if (a_reg[2] > big)
        begin
            big = a_reg[2];
        end
        case (k_reg)
            2'd0:    begin a_sel = a_reg[0]; sq_sel = sq_reg[0]; end
            2'd1:    begin a_sel = a_reg[1]; sq_sel = sq_reg[1]; end
            default: begin a_sel = a_reg[2]; sq_sel = sq_reg[2]; end
        endcase
        q    = r_reg | bit_reg;
        t    = {q, 1'b0} - 16'd1;
        lhs  = (66'(phi_reg) << 17) + 66'(plo_reg);
        rhs  = 66'(sq_sel) << 30;
        take = (q <= ONE) && (lhs <= rhs);
    end

    assign done   = (state_reg == N_OUT);
    assign res.nx = neg_reg[0] ? -FIELD_W'(m_reg[0]) : FIELD_W'(m_reg[0]);
    assign res.ny = neg_reg[1] ? -FIELD_W'(m_reg[1]) : FIELD_W'(m_reg[1]);
    assign res.nz = neg_reg[2] ? -FIELD_W'(m_reg[2]) : FIELD_W'(m_reg[2]);
    assign res.zero = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ((sum_x == '0) && (sum_y == '0) && (sum_z == '0))
                                     ? N_OUT : N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (big[SUM_W-1:16] == '0)
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= N_TSQ;
                    end
                end
                N_TSQ:   state_reg <= N_MUL;
                N_MUL:   state_reg <= N_CMP;
                N_CMP:
                begin
                    if (bit_reg[0] && (k_reg == 2'd2))
                    begin
                        state_reg <= N_OUT;
                    end
                    else
                    begin
                        state_reg <= N_TSQ;
                    end
                end
                N_OUT:   state_reg <= N_IDLE;
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    // datapath: magnitudes, shifts, squares, quotient bits
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                a_reg[0]   <= sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
                a_reg[1]   <= sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
                a_reg[2]   <= sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);
                neg_reg[0] <= sum_x[SUM_W-1];
                neg_reg[1] <= sum_y[SUM_W-1];
                neg_reg[2] <= sum_z[SUM_W-1];
                zero_reg   <= (sum_x == '0) && (sum_y == '0) && (sum_z == '0);
                m_reg[0]   <= '0;
                m_reg[1]   <= '0;
                m_reg[2]   <= '0;
                k_reg      <= 2'd0;
                len_reg    <= '0;
            end
            N_SHIFT:
            begin
                // drop eight bits while at least eight shifts remain
                if (big[SUM_W-1:23] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] >> 8;
                    end
                end
                else if (big[SUM_W-1:16] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] >> 1;
                    end
                end
            end
            N_SQ:
            begin
                sq_reg[k_reg] <= 32'(a_sel[15:0]) * 32'(a_sel[15:0]);
                len_reg       <= len_reg + 34'(32'(a_sel[15:0]) * 32'(a_sel[15:0]));
                k_reg         <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                r_reg         <= '0;
                bit_reg       <= ONE;
            end
            N_TSQ:
            begin
                tt_reg <= 32'(t) * 32'(t);
            end
            N_MUL:
            begin
                plo_reg <= 49'(tt_reg) * 49'(len_reg[16:0]);
                phi_reg <= 49'(tt_reg) * 49'(len_reg[33:17]);
            end
            N_CMP:
            begin
                if (bit_reg[0])
                begin
                    m_reg[k_reg] <= take ? q : r_reg;
                    r_reg        <= '0;
                    bit_reg      <= ONE;
                    k_reg        <= k_reg + 2'd1;
                end
                else
                begin
                    if (take)
                    begin
                        r_reg <= q;
                    end
                    bit_reg <= bit_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/vna_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vna_back
// Execution side: sequences memory reads, the cross product, saturating
// accumulation and normalization for one queued transaction at a time.
// ----------------------------------------------------------------------------
module vna_back
    import vna_pkg::*;
#(
    parameter int VERTEX_DEPTH  = 4096,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire in_item_t                        q_item,
    output logic                                 q_pop,
    output logic                                 pos_we,
    output logic [$clog2(VERTEX_DEPTH)-1:0]      pos_waddr,
    output logic [3*POSITION_BITS-1:0]           pos_wdata,
    output logic [$clog2(VERTEX_DEPTH)-1:0]      pos_raddr,
    input  wire logic [3*POSITION_BITS-1:0]      pos_rdata,
    output logic                                 sum_we,
    output logic [$clog2(VERTEX_DEPTH)-1:0]      sum_waddr,
    output logic [3*SUM_W-1:0]                   sum_wdata,
    output logic [$clog2(VERTEX_DEPTH)-1:0]      sum_raddr,
    input  wire logic [3*SUM_W-1:0]              sum_rdata,
    output logic                                 done_valid,
    output out_item_t                            done_item,
    input  wire logic                            done_ready
);

    localparam int PB    = POSITION_BITS;
    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int E_W   = PB + 1;
    localparam int P_W   = 2 * E_W;
    localparam int N_W   = P_W + 1;
    localparam int ADD_W = ((N_W > SUM_W) ? N_W : SUM_W) + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_PB       = 4'd2;
    localparam logic [3:0] S_PC       = 4'd3;
    localparam logic [3:0] S_EDGE     = 4'd4;
    localparam logic [3:0] S_CROSS    = 4'd5;
    localparam logic [3:0] S_ACC_RD   = 4'd6;
    localparam logic [3:0] S_ACC_WR   = 4'd7;
    localparam logic [3:0] S_RWAIT    = 4'd8;
    localparam logic [3:0] S_NORM     = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]             state_reg;
    in_item_t               item_reg;
    out_item_t              build_reg;
    logic signed [PB-1:0]   pa_reg  [3];
    logic signed [PB-1:0]   pb_reg  [3];
    logic signed [E_W-1:0]  e0_reg  [3];
    logic signed [E_W-1:0]  e1_reg  [3];
    logic signed [P_W-1:0]  p1_reg, p2_reg;
    logic signed [N_W-1:0]  n_reg   [3];
    logic [1:0]             cnt_reg;
    logic [1:0]             corner_reg;
    logic                   clip_reg;

    logic [AW-1:0]          addr_a, addr_b, addr_c, corner_addr;
    logic signed [E_W-1:0]  m1a, m1b, m2a, m2b;
    logic signed [SUM_W-1:0] acc  [3];
    logic signed [SUM_W-1:0] accn [3];
    logic [2:0]             clip_now;
    logic                   norm_start, norm_done;
    norm_res_t              norm_res;

    assign addr_a = AW'(item_reg.index_a);
    assign addr_b = AW'(item_reg.index_b);
    assign addr_c = AW'(item_reg.index_c);

    always_comb
    begin
        case (corner_reg)
            2'd0:    corner_addr = addr_a;
            2'd1:    corner_addr = addr_b;
            default: corner_addr = addr_c;
        endcase
    end

    // select cross-product operands for the current component
    always_comb
    begin
        case (cnt_reg)
            2'd0:    begin m1a = e0_reg[1]; m1b = e1_reg[2]; m2a = e0_reg[2]; m2b = e1_reg[1]; end
            2'd1:    begin m1a = e0_reg[2]; m1b = e1_reg[0]; m2a = e0_reg[0]; m2b = e1_reg[2]; end
            default: begin m1a = e0_reg[0]; m1b = e1_reg[1]; m2a = e0_reg[1]; m2b = e1_reg[0]; end
        endcase
    end

    // saturating add of the face normal to one corner's sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [ADD_W-1:0] s;
            acc[i] = sum_rdata[i*SUM_W +: SUM_W];
            s = ADD_W'(acc[i]) + ADD_W'(n_reg[i]);
            if (s > ADD_W'(SUM_MAX))
            begin
                accn[i]     = SUM_MAX;
                clip_now[i] = 1'b1;
            end
            else if (s < ADD_W'(SUM_MIN))
            begin
                accn[i]     = SUM_MIN;
                clip_now[i] = 1'b1;
            end
            else
            begin
                accn[i]     = SUM_W'(s);
                clip_now[i] = 1'b0;
            end
        end
    end

    // memory port control
    always_comb
    begin
        q_pop      = (state_reg == S_IDLE) && q_valid;
        pos_we     = (state_reg == S_DISPATCH) && (item_reg.operation == OP_WRITE);
        pos_waddr  = addr_a;
        pos_wdata  = {PB'($unsigned(item_reg.pos_z)), PB'($unsigned(item_reg.pos_y)),
                      PB'($unsigned(item_reg.pos_x))};
        case (state_reg)
            S_PB:    pos_raddr = addr_b;
            S_PC:    pos_raddr = addr_c;
            default: pos_raddr = addr_a;
        endcase
        sum_we     = pos_we || (state_reg == S_ACC_WR);
        sum_waddr  = (state_reg == S_ACC_WR) ? corner_addr : addr_a;
        sum_wdata  = (state_reg == S_ACC_WR) ? {accn[2], accn[1], accn[0]} : '0;
        sum_raddr  = (state_reg == S_ACC_RD) ? corner_addr : addr_a;
        norm_start = (state_reg == S_RWAIT);
        done_valid = (state_reg == S_DONE);
        done_item  = build_reg;
    end

    vna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .sum_x (sum_rdata[0 +: SUM_W]),
        .sum_y (sum_rdata[SUM_W +: SUM_W]),
        .sum_z (sum_rdata[2*SUM_W +: SUM_W]),
        .done  (norm_done),
        .res   (norm_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (item_reg.operation)
                        OP_TRI:  state_reg <= S_PB;
                        OP_READ: state_reg <= S_RWAIT;
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_PB:     state_reg <= S_PC;
                S_PC:     state_reg <= S_EDGE;
                S_EDGE:   state_reg <= S_CROSS;
                S_CROSS:
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_ACC_RD;
                    end
                end
                S_ACC_RD: state_reg <= S_ACC_WR;
                S_ACC_WR: state_reg <= (corner_reg == 2'd2) ? S_DONE : S_ACC_RD;
                S_RWAIT:  state_reg <= S_NORM;
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (done_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg   <= q_item;
                build_reg  <= {q_item.operation, {($bits(out_item_t)-2){1'b0}}};
                clip_reg   <= 1'b0;
                cnt_reg    <= 2'd0;
                corner_reg <= 2'd0;
            end
            S_PB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pa_reg[i] <= pos_rdata[i*PB +: PB];
                end
            end
            S_PC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pb_reg[i] <= pos_rdata[i*PB +: PB];
                end
            end
            S_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e0_reg[i] <= E_W'(pb_reg[i]) - E_W'(pa_reg[i]);
                    e1_reg[i] <= E_W'($signed(pos_rdata[i*PB +: PB])) - E_W'(pa_reg[i]);
                end
            end
            S_CROSS:
            begin
                // multiply for this component, subtract for the previous one
                p1_reg <= P_W'(m1a) * P_W'(m1b);
                p2_reg <= P_W'(m2a) * P_W'(m2b);
                if (cnt_reg != 2'd0)
                begin
                    n_reg[cnt_reg - 2'd1] <= N_W'(p1_reg) - N_W'(p2_reg);
                end
                cnt_reg <= cnt_reg + 2'd1;
            end
            S_ACC_WR:
            begin
                clip_reg   <= clip_reg || (clip_now != 3'b000);
                corner_reg <= corner_reg + 2'd1;
                if (corner_reg == 2'd2)
                begin
                    build_reg.saturated <= clip_reg || (clip_now != 3'b000);
                end
            end
            S_NORM:
            begin
                if (norm_done)
                begin
                    build_reg.normal_x    <= norm_res.nx;
                    build_reg.normal_y    <= norm_res.ny;
                    build_reg.normal_z    <= norm_res.nz;
                    build_reg.zero_length <= norm_res.zero;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_acc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC_WR) && (corner_reg == 2'd2) |=> (state_reg == S_DONE))
        else $error("accumulation did not finish after third corner");

    a_norm_wait: assert property (@(posedge clk) disable iff (!rst_n)
        norm_start |=> (state_reg == S_NORM))
        else $error("normalizer start not followed by wait state");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done_valid && !done_ready |=> done_valid && $stable(done_item))
        else $error("finished result changed before it was taken");

    a_pos_write_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC_WR) |-> !pos_we && (item_reg.operation == OP_TRI))
        else $error("accumulator write outside triangle transaction");

endmodule
`default_nettype wire

>>> hw/rtl/vertex_normal_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Smooth vertex normals: stores positions, accumulates triangle face normals
// into saturating 40-bit sums, and returns unit normals in Q1.14.
// A read runs the normalizer: a shift search, then three 15-step quotient
//   searches, each step through its square, multiply and compare states;
//   a read of a zero-length sum skips both.
// One transaction executes at a time; the input queue takes 2 more meanwhile
//   and a finished result waits in the output register.
// Reset clears queue, sequencer and output-valid state; memory stays unknown.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_DEPTH  = 4096,
    parameter int POSITION_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire in_item_t  item,
    output logic           full,
    output logic           empty,
    output out_item_t      result,
    input  wire logic      pop
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    logic                        q_valid, q_pop;
    in_item_t                    q_item;
    logic                        pos_we, sum_we;
    logic [AW-1:0]               pos_waddr, pos_raddr, sum_waddr, sum_raddr;
    logic [3*POSITION_BITS-1:0]  pos_wdata, pos_rdata;
    logic [3*SUM_W-1:0]          sum_wdata, sum_rdata;
    logic                        done_valid, done_ready;
    out_item_t                   done_item;
    logic                        res_valid_reg;
    out_item_t                   res_reg;

    vna_front #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    vna_ram #(
        .WIDTH (3 * POSITION_BITS),
        .DEPTH (VERTEX_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(
        .WIDTH (3 * SUM_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    vna_back #(
        .VERTEX_DEPTH  (VERTEX_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata),
        .sum_we     (sum_we),
        .sum_waddr  (sum_waddr),
        .sum_wdata  (sum_wdata),
        .sum_raddr  (sum_raddr),
        .sum_rdata  (sum_rdata),
        .done_valid (done_valid),
        .done_item  (done_item),
        .done_ready (done_ready)
    );

    // output register: take a finished result when free or being popped
    assign done_ready = !res_valid_reg || pop;
    assign empty      = !res_valid_reg;
    assign result     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            res_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            res_reg <= done_item;
        end
    end

endmodule
`default_nettype wire
